@@ design/icls_pkg.sv @@
// Shared types and codes for the inverse-CDF length sampler.
package icls_pkg;

    // Field widths that the item format fixes.
    localparam int WEIGHT_W = 32;
    localparam int LENGTH_W = 16;
    localparam int VALUE_W  = 48;

    // Mode codes carried by an input item.
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Operation classes handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_QUERY,
        OP_NOP
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_FULL,
        STATUS_RANGE
    } status_t;

    // Back end sequencer states.
    typedef enum logic {
        BS_IDLE,
        BS_SEARCH
    } back_state_t;

    // One classified item waiting in the queue.
    typedef struct packed {
        op_t                 op;
        logic [WEIGHT_W-1:0] weight;
        logic [LENGTH_W-1:0] length;
        logic [VALUE_W-1:0]  value;
    } item_t;

endpackage

@@ design/icls_front.sv @@
// Front end: accepts input items, classifies them and queues them for the back end.
module icls_front
    import icls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [WEIGHT_W-1:0] entry_weight,
    input  logic [LENGTH_W-1:0] entry_length,
    input  logic [VALUE_W-1:0]  query_value,
    output logic                item_valid,
    output item_t               item,
    input  logic                item_pop
);

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    item_t      incoming;

    // Decode the mode field into an operation class.
    always_comb
    begin
        incoming.weight = entry_weight;
        incoming.length = entry_length;
        incoming.value  = query_value;
        unique case (mode)
            MODE_CLEAR:  incoming.op = OP_CLEAR;
            MODE_LOAD:   incoming.op = OP_LOAD;
            MODE_QUERY:  incoming.op = OP_QUERY;
            MODE_UNUSED: incoming.op = OP_NOP;
        endcase
    end

    // Two-entry queue; the input stalls only when both slots are taken.
    assign in_stall   = (fill_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign item_valid = (fill_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, item_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue slots hold payload only and need no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

@@ design/icls_back.sv @@
// Back end: table memory, load and clear handling, binary search and result register.
module icls_back
    import icls_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int SUM_BITS    = 48
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  item_t                        item,
    output logic                         item_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [LENGTH_W-1:0]          sampled_length,
    output logic [1:0]                   status,
    output logic                         searching,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] fill_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = SUM_BITS + LENGTH_W;
    localparam int EW    = (SUM_BITS > WEIGHT_W ? SUM_BITS : WEIGHT_W) + 1;
    localparam int CW    = (SUM_BITS > VALUE_W ? SUM_BITS : VALUE_W);

    // Table memory: each word holds {length, cumulative weight}.
    logic [ENT_W-1:0]    mem [TABLE_DEPTH];
    logic [ENT_W-1:0]    rd_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;

    back_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_BITS-1:0] total_reg, total_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    mid_reg, mid_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [LENGTH_W-1:0] best_reg, best_next;

    logic                out_valid_reg, out_valid_next;
    logic [LENGTH_W-1:0] len_reg, len_next;
    status_t             status_reg, status_next;

    logic                out_free;
    logic [EW-1:0]       sum_ext;
    logic [SUM_BITS-1:0] new_total;
    logic                ge;
    logic [CNT_W-1:0]    lo_step, hi_step;
    logic [SUM_BITS-1:0] rd_cum;
    logic [LENGTH_W-1:0] rd_len;

    assign rd_cum   = rd_reg[SUM_BITS-1:0];
    assign rd_len   = rd_reg[ENT_W-1:SUM_BITS];
    assign out_free = !out_valid_reg || !out_stall;

    // Saturating running total for a load.
    assign sum_ext   = EW'(total_reg) + EW'(item.weight);
    assign new_total = (sum_ext > EW'({SUM_BITS{1'b1}})) ? {SUM_BITS{1'b1}}
                                                          : sum_ext[SUM_BITS-1:0];

    // One search probe: compare the word read at mid against the target.
    always_comb
    begin
        ge      = (CW'(rd_cum) >= CW'(value_reg));
        lo_step = ge ? lo_reg : mid_reg + CNT_W'(1);
        hi_step = ge ? mid_reg : hi_reg;
    end

    // Sequencer: takes one item at a time; a query within range stays in the search state.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        value_next     = value_reg;
        best_next      = best_reg;
        item_pop       = 1'b0;
        wr_en          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        len_next       = len_reg;
        status_next    = status_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (item_valid && out_free)
                begin
                    item_pop = 1'b1;
                    unique case (item.op)
                        OP_CLEAR:
                        begin
                            count_next     = '0;
                            total_next     = '0;
                            out_valid_next = 1'b1;
                            len_next       = '0;
                            status_next    = STATUS_OK;
                        end
                        OP_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            len_next       = '0;
                            if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                total_next  = new_total;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = STATUS_OK;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (count_reg == '0 || CW'(item.value) > CW'(total_reg))
                            begin
                                out_valid_next = 1'b1;
                                len_next       = '0;
                                status_next    = STATUS_RANGE;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                mid_next   = count_reg >> 1;
                                value_next = item.value;
                                state_next = BS_SEARCH;
                            end
                        end
                        OP_NOP:
                        begin
                            out_valid_next = 1'b1;
                            len_next       = '0;
                            status_next    = STATUS_OK;
                        end
                    endcase
                end
            end
            BS_SEARCH:
            begin
                if (ge)
                begin
                    best_next = rd_len;
                end
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step == hi_step)
                begin
                    // The last hit is the first entry at or above the target.
                    out_valid_next = 1'b1;
                    len_next       = ge ? rd_len : best_reg;
                    status_next    = STATUS_OK;
                    state_next     = BS_IDLE;
                end
                else
                begin
                    mid_next = lo_step + ((hi_step - lo_step) >> 1);
                end
            end
        endcase
        rd_addr = mid_next[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Search and result payload registers.
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        value_reg  <= value_next;
        best_reg   <= best_next;
        len_reg    <= len_next;
        status_reg <= status_next;
    end

    // Table memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= {item.length, new_total};
        end
        rd_reg <= mem[rd_addr];
    end

    assign out_valid      = out_valid_reg;
    assign sampled_length = len_reg;
    assign status         = status_reg;
    assign searching      = (state_reg == BS_SEARCH);
    assign fill_count     = count_reg;

endmodule

@@ design/inverse_cdf_length_sampler_unit.sv @@
// Top level of the inverse-CDF length sampler: front end, queue and search back end.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   input   | in_valid, in_stall, mode, entry_weight,          | in
//           | entry_length, query_value                        |
//   result  | out_valid, out_stall, sampled_length, status     | out
//
// Clear, load, unused-mode and rejected query items finish in the back end's idle state.
// Any other query moves to the search state and probes the table memory's registered
// read port up to ceil(log2(entries + 1)) times, eleven for a 1024-entry table.
// Reset clears the entry count, the running total and all handshake state; the table
// memory is not cleared, since only entries below the count are ever read.
// The two-entry queue accepts items during a result stall until both slots are taken.
module inverse_cdf_length_sampler_unit
    import icls_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int SUM_BITS    = 48
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [WEIGHT_W-1:0] entry_weight,
    input  logic [LENGTH_W-1:0] entry_length,
    input  logic [VALUE_W-1:0]  query_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LENGTH_W-1:0] sampled_length,
    output logic [1:0]          status
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic             item_valid;
    item_t            item;
    logic             item_pop;
    logic             searching;
    logic [CNT_W-1:0] fill_count;

    icls_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .entry_weight (entry_weight),
        .entry_length (entry_length),
        .query_value  (query_value),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop)
    );

    icls_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SUM_BITS    (SUM_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sampled_length (sampled_length),
        .status         (status),
        .searching      (searching),
        .fill_count     (fill_count)
    );

    // The result register is always empty while a search runs.
    assert property (@(posedge clk) disable iff (!rst_n) searching |-> !out_valid)
        else $error("result register occupied during a search");

    // The entry count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A failed item never carries a length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> (sampled_length == '0))
        else $error("nonzero length on a failed item");

    // The queue is never popped while the back end is searching.
    assert property (@(posedge clk) disable iff (!rst_n) searching |-> !item_pop)
        else $error("queue popped during a search");

endmodule
